@@ rtl/zlp_pkg.sv @@
// ----------------------------------------------------------------------------
// zlp_pkg
// Types and constants shared by the ZIP local header stream parser: payload
// structs, parser phases, result kinds, end status codes and signatures.
// ----------------------------------------------------------------------------
package zlp_pkg;

   // record signatures as seen in the little-endian sliding window
   localparam logic [31:0] SIG_LFH  = 32'h0403_4B50;
   localparam logic [31:0] SIG_CD   = 32'h0201_4B50;
   localparam logic [31:0] SIG_EOCD = 32'h0605_4B50;
   localparam logic [31:0] SIG_DESC = 32'h0807_4B50;

   // local header byte offsets
   localparam logic [4:0] OFS_METHOD_LO = 5'd8;
   localparam logic [4:0] OFS_METHOD_HI = 5'd9;
   localparam logic [4:0] OFS_PACKED_B0 = 5'd18;
   localparam logic [4:0] OFS_PACKED_B1 = 5'd19;
   localparam logic [4:0] OFS_PACKED_B2 = 5'd20;
   localparam logic [4:0] OFS_PACKED_B3 = 5'd21;
   localparam logic [4:0] OFS_PLAIN_B0  = 5'd22;
   localparam logic [4:0] OFS_PLAIN_B1  = 5'd23;
   localparam logic [4:0] OFS_PLAIN_B2  = 5'd24;
   localparam logic [4:0] OFS_PLAIN_B3  = 5'd25;
   localparam logic [4:0] OFS_NAME_LO   = 5'd26;
   localparam logic [4:0] OFS_NAME_HI   = 5'd27;
   localparam logic [4:0] OFS_EXTRA_LO  = 5'd28;
   localparam logic [4:0] OFS_EXTRA_HI  = 5'd29;

   localparam logic [31:0] HDR_LAST    = 32'd29;
   localparam logic [31:0] SIG_BYTES   = 32'd4;
   localparam logic [31:0] DESC_LEN    = 32'd16;
   localparam logic [31:0] NAME_LIMIT  = 32'd255;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [15:0] METHOD_STORED  = 16'd0;
   localparam logic [15:0] METHOD_DEFLATE = 16'd8;

   // result kinds
   localparam logic [1:0] KIND_HEADER   = 2'd0;
   localparam logic [1:0] KIND_NAME     = 2'd1;
   localparam logic [1:0] KIND_DATA     = 2'd2;
   localparam logic [1:0] KIND_FINISHED = 2'd3;

   // end status codes
   localparam logic [1:0] END_NORMAL    = 2'd0;
   localparam logic [1:0] END_DIRECTORY = 2'd1;
   localparam logic [1:0] END_TRUNCATED = 2'd2;

   typedef enum logic [2:0] {
      PH_SCAN   = 3'd0,
      PH_HEADER = 3'd1,
      PH_NAME   = 3'd2,
      PH_EXTRA  = 3'd3,
      PH_DATA   = 3'd4,
      PH_POST   = 3'd5,
      PH_DESC   = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [15:0] method;
      logic [31:0] packed_size;
      logic [31:0] plain_size;
      logic [15:0] name_length;
      logic        method_supported;
      logic [15:0] entries_done;
      logic [1:0]  end_status;
      logic        run_last;
   } rsp_type;

   // results produced by one byte, in order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

@@ rtl/zlp_parser.sv @@
// ----------------------------------------------------------------------------
// zlp_parser
// Parser state registers and the single-pass next-state logic. Each byte
// transfer updates the state and yields zero, one or two results.
// ----------------------------------------------------------------------------
module zlp_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  zlp_pkg::req_type item,
   output zlp_pkg::push_type push
);
   import zlp_pkg::*;

   logic [31:0] win_ff, win_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [15:0] method_ff, method_in;
   logic [31:0] packed_ff, packed_in;
   logic [31:0] plain_ff, plain_in;
   logic [15:0] name_ff, name_in;
   logic [15:0] extra_ff, extra_in;
   logic [15:0] entries_ff, entries_in;

   logic [7:0]  b;
   logic        fin;
   logic [31:0] win_shift;
   logic [31:0] cnt_inc;
   logic        scan_stop;
   logic        scan_lfh;
   logic        entry_end;
   logic        first_v;
   logic [1:0]  first_kind;
   logic [7:0]  first_byte;
   logic [1:0]  first_status;
   logic        fin_v;
   logic [1:0]  fin_status;
   logic        supported;
   logic [15:0] entries_after;
   rsp_type     res_first;
   rsp_type     res_fin;

   assign b         = item.data_byte;
   assign fin       = item.is_final;
   assign win_shift = {b, win_ff[31:8]};
   assign cnt_inc   = cnt_ff + 32'd1;
   assign scan_stop = (win_shift == SIG_CD) || (win_shift == SIG_EOCD);
   assign scan_lfh  = (win_shift == SIG_LFH);

   // next state and results for one byte
   always_comb begin
      win_in       = win_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      method_in    = method_ff;
      packed_in    = packed_ff;
      plain_in     = plain_ff;
      name_in      = name_ff;
      extra_in     = extra_ff;
      entries_in   = entries_ff;
      entry_end    = 1'b0;
      first_v      = 1'b0;
      first_kind   = KIND_HEADER;
      first_byte   = 8'd0;
      first_status = END_NORMAL;

      case (phase_ff)
         PH_SCAN, PH_POST: begin
            win_in = win_shift;
            if (phase_ff == PH_POST) begin
               cnt_in = cnt_inc;
            end
            if (phase_ff == PH_SCAN || cnt_inc >= SIG_BYTES) begin
               if (phase_ff == PH_POST && win_shift == SIG_DESC) begin
                  phase_in = PH_DESC;
               end else if (scan_stop) begin
                  phase_in     = PH_DONE;
                  first_v      = 1'b1;
                  first_kind   = KIND_FINISHED;
                  first_status = END_DIRECTORY;
               end else if (scan_lfh) begin
                  phase_in  = PH_HEADER;
                  cnt_in    = SIG_BYTES;
                  method_in = '0;
                  packed_in = '0;
                  plain_in  = '0;
                  name_in   = '0;
                  extra_in  = '0;
               end else begin
                  phase_in = PH_SCAN;
               end
            end
         end
         PH_DESC: begin
            cnt_in = cnt_inc;
            if (cnt_inc >= DESC_LEN) begin
               phase_in = PH_SCAN;
               win_in   = '0;
               cnt_in   = '0;
            end
         end
         PH_HEADER: begin
            // little-endian header fields
            case (cnt_ff[4:0])
               OFS_METHOD_LO: method_in[7:0]   = b;
               OFS_METHOD_HI: method_in[15:8]  = b;
               OFS_PACKED_B0: packed_in[7:0]   = b;
               OFS_PACKED_B1: packed_in[15:8]  = b;
               OFS_PACKED_B2: packed_in[23:16] = b;
               OFS_PACKED_B3: packed_in[31:24] = b;
               OFS_PLAIN_B0:  plain_in[7:0]    = b;
               OFS_PLAIN_B1:  plain_in[15:8]   = b;
               OFS_PLAIN_B2:  plain_in[23:16]  = b;
               OFS_PLAIN_B3:  plain_in[31:24]  = b;
               OFS_NAME_LO:   name_in[7:0]     = b;
               OFS_NAME_HI:   name_in[15:8]    = b;
               OFS_EXTRA_LO:  extra_in[7:0]    = b;
               OFS_EXTRA_HI:  extra_in[15:8]   = b;
               default: ;
            endcase
            cnt_in = cnt_inc;
            if (cnt_ff == HDR_LAST) begin
               first_v    = 1'b1;
               first_kind = KIND_HEADER;
               cnt_in     = '0;
               if (name_in != 16'd0) begin
                  phase_in = PH_NAME;
               end else if (extra_in != 16'd0) begin
                  phase_in = PH_EXTRA;
               end else if (packed_in != 32'd0) begin
                  phase_in = PH_DATA;
               end else begin
                  entry_end = 1'b1;
               end
            end
         end
         PH_NAME: begin
            if (cnt_ff < NAME_LIMIT) begin
               first_v    = 1'b1;
               first_kind = KIND_NAME;
               first_byte = b;
            end
            cnt_in = cnt_inc;
            if (cnt_inc >= {16'd0, name_ff}) begin
               cnt_in = '0;
               if (extra_ff != 16'd0) begin
                  phase_in = PH_EXTRA;
               end else if (packed_ff != 32'd0) begin
                  phase_in = PH_DATA;
               end else begin
                  entry_end = 1'b1;
               end
            end
         end
         PH_EXTRA: begin
            cnt_in = cnt_inc;
            if (cnt_inc >= {16'd0, extra_ff}) begin
               cnt_in = '0;
               if (packed_ff != 32'd0) begin
                  phase_in = PH_DATA;
               end else begin
                  entry_end = 1'b1;
               end
            end
         end
         PH_DATA: begin
            if (method_ff == METHOD_STORED || method_ff == METHOD_DEFLATE) begin
               first_v    = 1'b1;
               first_kind = KIND_DATA;
               first_byte = b;
            end
            cnt_in = cnt_inc;
            if (cnt_inc >= packed_ff) begin
               entry_end = 1'b1;
            end
         end
         default: ;
      endcase

      // entry completion
      supported = (method_in == METHOD_STORED) || (method_in == METHOD_DEFLATE);
      if (entry_end) begin
         if (supported && entries_ff != COUNT_MAX) begin
            entries_in = entries_ff + 16'd1;
         end
         phase_in = PH_POST;
         win_in   = '0;
         cnt_in   = '0;
      end
      entries_after = entries_in;

      // final byte of the archive
      fin_v      = fin && (phase_ff != PH_DONE) && (phase_in != PH_DONE);
      fin_status = (phase_in == PH_HEADER || phase_in == PH_NAME ||
                    phase_in == PH_EXTRA || phase_in == PH_DATA) ?
                   END_TRUNCATED : END_NORMAL;

      res_first.kind             = first_kind;
      res_first.byte_value       = first_byte;
      res_first.method           = method_in;
      res_first.packed_size      = packed_in;
      res_first.plain_size       = plain_in;
      res_first.name_length      = name_in;
      res_first.method_supported = supported;
      res_first.entries_done     = entries_ff;
      res_first.end_status       = first_status;
      res_first.run_last         = !fin_v;

      res_fin              = res_first;
      res_fin.kind         = KIND_FINISHED;
      res_fin.byte_value   = 8'd0;
      res_fin.entries_done = entries_after;
      res_fin.end_status   = fin_status;
      res_fin.run_last     = 1'b1;

      // back to the reset state after the final byte
      if (fin) begin
         win_in     = '0;
         phase_in   = PH_SCAN;
         cnt_in     = '0;
         method_in  = '0;
         packed_in  = '0;
         plain_in   = '0;
         name_in    = '0;
         extra_in   = '0;
         entries_in = '0;
      end

      // pack results in order
      push.count  = {1'b0, first_v} + {1'b0, fin_v};
      push.first  = first_v ? res_first : res_fin;
      push.second = res_fin;
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= '0;
         phase_ff   <= PH_SCAN;
         cnt_ff     <= '0;
         method_ff  <= '0;
         packed_ff  <= '0;
         plain_ff   <= '0;
         name_ff    <= '0;
         extra_ff   <= '0;
         entries_ff <= '0;
      end else if (accept) begin
         win_ff     <= win_in;
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         method_ff  <= method_in;
         packed_ff  <= packed_in;
         plain_ff   <= plain_in;
         name_ff    <= name_in;
         extra_ff   <= extra_in;
         entries_ff <= entries_in;
      end
   end

endmodule

@@ rtl/zlp_result_fifo.sv @@
// ----------------------------------------------------------------------------
// zlp_result_fifo
// Result queue between parser and output channel. Takes up to two results
// per cycle and presents the oldest one from a register.
// ----------------------------------------------------------------------------
module zlp_result_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  zlp_pkg::push_type           push,
   output logic                        out_valid,
   input  logic                        out_ready,
   output zlp_pkg::rsp_type            out_data,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   import zlp_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   rsp_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [LW-1:0]   level_ff, level_in;
   logic [PW-1:0]   wr_next;
   logic            pop;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign wr_next   = ptr_inc(wr_ff);
   assign out_valid = (level_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign level     = level_ff;

   // pointer and fill level update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = pop ? ptr_inc(rd_ff) : rd_ff;
      level_in = level_ff + LW'(push.count) - LW'(pop);
      case (push.count)
         2'd1:    wr_in = wr_next;
         2'd2:    wr_in = ptr_inc(wr_next);
         default: wr_in = wr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule

@@ rtl/zip_local_header_stream_parser_top.sv @@
// Results: each result is registered in the result queue at its byte transfer.
// Throughput: one byte per cycle; each byte gives up to two results, queued in
// FIFO_DEPTH result registers, and req_ready is high while two entries are free.
// Output: one result per cycle from the queue read port while rsp_ready is high.
// Reset: synchronous, active high; clears parser state and empties the queue.
// ----------------------------------------------------------------------------
// zip_local_header_stream_parser_top
// Byte-stream ZIP local header parser: parser stage feeding a result queue.
// ----------------------------------------------------------------------------
module zip_local_header_stream_parser_top #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  zlp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output zlp_pkg::rsp_type rsp_data
);
   import zlp_pkg::*;

   localparam int LW = $clog2(FIFO_DEPTH + 1);

   logic          req_fire;
   push_type      push;
   logic [LW-1:0] level;

   // room for the two results a byte may give
   assign req_ready = (level <= LW'(FIFO_DEPTH - 2));
   assign req_fire  = req_valid && req_ready;

   zlp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (req_fire),
      .item   (req_data),
      .push   (push)
   );

   zlp_result_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data),
      .level     (level)
   );

   // results only come from a byte transfer
   a_push_on_fire: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> req_fire)
      else $error("results pushed without a byte transfer");

   // queue never overfills
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      level <= LW'(FIFO_DEPTH))
      else $error("result queue overflow");

   // a pair of results ends on the second one only
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.second.run_last && !push.first.run_last))
      else $error("run_last misplaced in result pair");

   // a waiting queue holds its level when nothing is taken and no byte is accepted
   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && !req_fire) |=> $stable(level))
      else $error("queue level changed without traffic");

endmodule

@@ sim/tb_zip_local_header_stream_parser_top.sv @@
// ----------------------------------------------------------------------------
// tb_zip_local_header_stream_parser_top
// Self-checking bench for the ZIP local header stream parser. Hand-built
// archives cover the corner cases: lone final byte, directory and end records,
// cuts inside header, name, extra and data, descriptors, unsupported methods
// and maximum field values. Random archives with noise and cuts follow. A
// scoreboard class tracks the parser state per accepted byte and checks every
// result field in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_zip_local_header_stream_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   import zlp_pkg::*;

   localparam int unsigned BYTES_PER_PHASE = 60;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned NAME_CAP        = 260;
   localparam int unsigned DATA_CAP        = 20;

   // tracks parser state per byte and holds the results still to come
   class parser_scoreboard;
      rsp_type     pending_results[$];
      rsp_type     step_out[$];
      logic [31:0] window;
      phase_type   stage;
      logic [31:0] section_pos;
      logic [15:0] entry_method;
      logic [31:0] entry_packed;
      logic [31:0] entry_plain;
      logic [15:0] entry_name_len;
      logic [15:0] entry_extra_len;
      logic [15:0] entries_counted;
      int unsigned bytes_seen, results_checked, errors;
      int unsigned headers_seen, truncations_seen, directories_seen;

      function new();
         restart();
      endfunction

      function void restart();
         window          = '0;
         stage           = PH_SCAN;
         section_pos     = '0;
         entry_method    = '0;
         entry_packed    = '0;
         entry_plain     = '0;
         entry_name_len  = '0;
         entry_extra_len = '0;
         entries_counted = '0;
      endfunction

      function bit supported();
         return entry_method == METHOD_STORED || entry_method == METHOD_DEFLATE;
      endfunction

      function void push_result(logic [1:0] kind, logic [7:0] value, logic [1:0] status);
         rsp_type r;
         if (step_out.size() >= 2) return;
         r.kind             = kind;
         r.byte_value       = value;
         r.method           = entry_method;
         r.packed_size      = entry_packed;
         r.plain_size       = entry_plain;
         r.name_length      = entry_name_len;
         r.method_supported = supported();
         r.entries_done     = entries_counted;
         r.end_status       = status;
         r.run_last         = 1'b0;
         step_out.push_back(r);
      endfunction

      function void close_entry();
         if (supported() && entries_counted != COUNT_MAX) entries_counted++;
         stage       = PH_POST;
         window      = '0;
         section_pos = '0;
      endfunction

      // skip the empty sections that follow
      function void advance_section(phase_type from);
         section_pos = '0;
         if (from < PH_NAME && entry_name_len != 0) stage = PH_NAME;
         else if (from < PH_EXTRA && entry_extra_len != 0) stage = PH_EXTRA;
         else if (from < PH_DATA && entry_packed != 0) stage = PH_DATA;
         else close_entry();
      endfunction

      function void check_window();
         if (window == SIG_CD || window == SIG_EOCD) begin
            stage = PH_DONE;
            push_result(KIND_FINISHED, 8'h00, END_DIRECTORY);
         end else if (window == SIG_LFH) begin
            stage           = PH_HEADER;
            section_pos     = SIG_BYTES;
            entry_method    = '0;
            entry_packed    = '0;
            entry_plain     = '0;
            entry_name_len  = '0;
            entry_extra_len = '0;
         end
      endfunction

      // work out the results of one accepted byte
      function void note_byte(req_type item);
         logic [7:0] b;
         bit         was_done;
         bit         in_entry;
         b        = item.data_byte;
         was_done = (stage == PH_DONE);
         step_out.delete();
         bytes_seen++;
         case (stage)
            PH_SCAN: begin
               window = {b, window[31:8]};
               check_window();
            end
            PH_POST: begin
               window = {b, window[31:8]};
               section_pos++;
               if (section_pos >= SIG_BYTES) begin
                  if (window == SIG_DESC) begin
                     stage = PH_DESC;
                  end else begin
                     stage = PH_SCAN;
                     check_window();
                  end
               end
            end
            PH_DESC: begin
               section_pos++;
               if (section_pos >= DESC_LEN) begin
                  stage       = PH_SCAN;
                  window      = '0;
                  section_pos = '0;
               end
            end
            PH_HEADER: begin
               case (section_pos)
                  OFS_METHOD_LO: entry_method[7:0]  = b;
                  OFS_METHOD_HI: entry_method[15:8] = b;
                  OFS_PACKED_B0, OFS_PACKED_B1, OFS_PACKED_B2, OFS_PACKED_B3:
                     entry_packed[8*(section_pos-OFS_PACKED_B0) +: 8] = b;
                  OFS_PLAIN_B0, OFS_PLAIN_B1, OFS_PLAIN_B2, OFS_PLAIN_B3:
                     entry_plain[8*(section_pos-OFS_PLAIN_B0) +: 8] = b;
                  OFS_NAME_LO:   entry_name_len[7:0]   = b;
                  OFS_NAME_HI:   entry_name_len[15:8]  = b;
                  OFS_EXTRA_LO:  entry_extra_len[7:0]  = b;
                  OFS_EXTRA_HI:  entry_extra_len[15:8] = b;
                  default: ;
               endcase
               section_pos++;
               if (section_pos > HDR_LAST) begin
                  push_result(KIND_HEADER, 8'h00, END_NORMAL);
                  advance_section(PH_HEADER);
               end
            end
            PH_NAME: begin
               if (section_pos < NAME_LIMIT) push_result(KIND_NAME, b, END_NORMAL);
               section_pos++;
               if (section_pos >= entry_name_len) advance_section(PH_NAME);
            end
            PH_EXTRA: begin
               section_pos++;
               if (section_pos >= entry_extra_len) advance_section(PH_EXTRA);
            end
            PH_DATA: begin
               if (supported()) push_result(KIND_DATA, b, END_NORMAL);
               section_pos++;
               if (section_pos >= entry_packed) close_entry();
            end
            default: ;
         endcase
         // last byte of the archive
         if (item.is_final) begin
            if (!was_done && stage != PH_DONE) begin
               in_entry = stage == PH_HEADER || stage == PH_NAME ||
                          stage == PH_EXTRA || stage == PH_DATA;
               push_result(KIND_FINISHED, 8'h00, in_entry ? END_TRUNCATED : END_NORMAL);
            end
            restart();
         end
         if (step_out.size() > 0) step_out[step_out.size()-1].run_last = 1'b1;
         foreach (step_out[i]) pending_results.push_back(step_out[i]);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing pending: kind %0d, value %0h", got.kind,
                   got.byte_value);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         if (want.kind == KIND_HEADER) headers_seen++;
         if (want.end_status == END_TRUNCATED) truncations_seen++;
         if (want.end_status == END_DIRECTORY) directories_seen++;
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("byte_value", 32'(want.byte_value), 32'(got.byte_value));
         compare_field("method", 32'(want.method), 32'(got.method));
         compare_field("packed_size", want.packed_size, got.packed_size);
         compare_field("plain_size", want.plain_size, got.plain_size);
         compare_field("name_length", 32'(want.name_length), 32'(got.name_length));
         compare_field("method_supported", 32'(want.method_supported),
                       32'(got.method_supported));
         compare_field("entries_done", 32'(want.entries_done), 32'(got.entries_done));
         compare_field("end_status", 32'(want.end_status), 32'(got.end_status));
         compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
      endfunction
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   parser_scoreboard sb = new();

   logic [7:0]  archive_bytes[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_asked    = 0;
   int unsigned hold_taken    = 0;
   int unsigned hold_left     = 0;
   int unsigned bytes_sent    = 0;
   int unsigned archives_sent = 0;

   zip_local_header_stream_parser_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      #(10_000_000);
      $display("tb_zip_local_header_stream_parser_top: FAIL");
      $finish;
   end

   // transfer monitor: inputs are noted before results are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // result receiver with random stalls and a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic void push_le(logic [31:0] value, int unsigned n);
      for (int unsigned i = 0; i < n; i++) archive_bytes.push_back(value[8*i +: 8]);
   endfunction

   function automatic void push_noise(int unsigned n);
      repeat (n) archive_bytes.push_back(8'($urandom_range(255)));
   endfunction

   // local header, name, extra, data and optional descriptor
   function automatic void add_entry(logic [15:0] meth, logic [31:0] psz, logic [31:0] usz,
                                     logic [15:0] nlen, logic [15:0] xlen, bit desc);
      push_le(SIG_LFH, 4);
      push_le($urandom, 4);
      push_le(32'(meth), 2);
      push_le($urandom, 4);
      push_le($urandom, 4);
      push_le(psz, 4);
      push_le(usz, 4);
      push_le(32'(nlen), 2);
      push_le(32'(xlen), 2);
      push_noise(nlen > NAME_CAP ? NAME_CAP : nlen);
      push_noise(xlen > NAME_CAP ? NAME_CAP : xlen);
      push_noise(psz > DATA_CAP ? DATA_CAP : psz);
      if (desc) begin
         push_le(SIG_DESC, 4);
         push_noise(12);
      end
   endfunction

   // send the first cut bytes, the last one flagged final
   task automatic send_archive(int unsigned cut);
      req_type item;
      for (int unsigned i = 0; i < cut; i++) begin
         item.data_byte = archive_bytes[i];
         item.is_final  = (i == cut - 1);
         send_byte(item);
      end
      bytes_sent += cut;
      archives_sent++;
      archive_bytes.delete();
   endtask

   task automatic random_archive();
      int unsigned n_entries;
      int unsigned cut;
      logic [15:0] meth;
      logic [31:0] psz;
      logic [15:0] nlen;
      n_entries = $urandom_range(0, 3);
      if ($urandom_range(3) == 0) push_noise($urandom_range(1, 5));
      for (int unsigned e = 0; e < n_entries; e++) begin
         case ($urandom_range(4))
            0, 1:    meth = METHOD_STORED;
            2, 3:    meth = METHOD_DEFLATE;
            default: meth = 16'($urandom_range(65535));
         endcase
         psz  = ($urandom_range(11) == 0) ? 32'($urandom) : 32'($urandom_range(16));
         nlen = ($urandom_range(39) == 0) ? 16'($urandom_range(250, 300))
                                          : 16'($urandom_range(6));
         add_entry(meth, psz, $urandom, nlen, 16'($urandom_range(4)),
                   $urandom_range(2) == 0);
         // stray bytes and a misplaced descriptor signature between entries
         case ($urandom_range(7))
            0: push_noise($urandom_range(1, 3));
            1: begin
               push_noise(1);
               push_le(SIG_DESC, 4);
            end
            2: push_le(32'h0000_4B50, 2);
            default: ;
         endcase
      end
      case ($urandom_range(3))
         0: begin
            push_le(SIG_CD, 4);
            push_noise($urandom_range(10));
         end
         1: begin
            push_le(SIG_EOCD, 4);
            push_noise(18);
         end
         default: ;
      endcase
      if (archive_bytes.size() == 0) push_noise(1);
      cut = ($urandom_range(4) == 0) ? $urandom_range(1, archive_bytes.size())
                                     : archive_bytes.size();
      send_archive(cut);
   endtask

   task automatic directed_archives();
      // lone final byte while hunting for a signature
      archive_bytes.push_back(8'hA5);
      send_archive(1);
      // stored entry with descriptor, then end record and bytes after it
      add_entry(METHOD_STORED, 32'd3, 32'd3, 16'd2, 16'd1, 1'b1);
      push_le(SIG_EOCD, 4);
      archive_bytes.push_back(8'h00);
      archive_bytes.push_back(8'hFF);
      send_archive(archive_bytes.size());
      // empty deflate entry ends on its last header byte, then the directory
      add_entry(METHOD_DEFLATE, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
      push_le(SIG_CD, 4);
      send_archive(archive_bytes.size());
      // unsupported method skips its data, next entry cut inside its header
      add_entry(16'hFFFF, 32'd2, 32'd0, 16'd1, 16'd0, 1'b0);
      add_entry(METHOD_DEFLATE, 32'd1, 32'd1, 16'd0, 16'd0, 1'b0);
      send_archive(archive_bytes.size() - 16);
      // largest sizes, cut inside data
      add_entry(METHOD_DEFLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0);
      send_archive(archive_bytes.size());
      // largest name and extra lengths, cut inside the name
      add_entry(METHOD_STORED, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0);
      send_archive(archive_bytes.size());
      // cut inside the extra field
      add_entry(METHOD_DEFLATE, 32'd0, 32'd0, 16'd0, 16'd5, 1'b0);
      send_archive(32);
      // final byte is the last descriptor byte
      add_entry(METHOD_STORED, 32'd1, 32'd1, 16'd0, 16'd0, 1'b1);
      send_archive(archive_bytes.size());
   endtask

   // stimulus
   initial begin
      int unsigned phase_start;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 77;
      directed_archives();
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 77;
            end
            1: begin
               send_idle_pct = 77;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // long receiver hold-off against a name and stored data
               hold_asked++;
               add_entry(METHOD_STORED, 32'd20, 32'd20, 16'd40, 16'd0, 1'b0);
               send_archive(archive_bytes.size());
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_PHASE) random_archive();
      end
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("run covered %0d archives, %0d bytes, %0d results checked", archives_sent,
               bytes_sent, sb.results_checked);
      $display("entry headers %0d, truncated ends %0d, directory ends %0d",
               sb.headers_seen, sb.truncations_seen, sb.directories_seen);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("tb_zip_local_header_stream_parser_top: PASS");
      end else begin
         $display("tb_zip_local_header_stream_parser_top: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/zlp_pkg.sv
rtl/zlp_parser.sv
rtl/zlp_result_fifo.sv
rtl/zip_local_header_stream_parser_top.sv
sim/tb_zip_local_header_stream_parser_top.sv
